// File: rtl/nasp_pkg.sv
package nasp_pkg;

    localparam int MAX_SUB_AUTHS = 15;

    // parser phases
    localparam logic [3:0] PH_REV    = 4'd0;
    localparam logic [3:0] PH_SIZE   = 4'd1;
    localparam logic [3:0] PH_COUNT  = 4'd2;
    localparam logic [3:0] PH_ETYPE  = 4'd3;
    localparam logic [3:0] PH_EFLAGS = 4'd4;
    localparam logic [3:0] PH_ESIZE  = 4'd5;
    localparam logic [3:0] PH_EMASK  = 4'd6;
    localparam logic [3:0] PH_SREV   = 4'd7;
    localparam logic [3:0] PH_SCOUNT = 4'd8;
    localparam logic [3:0] PH_SAUTH  = 4'd9;
    localparam logic [3:0] PH_SSUB   = 4'd10;
    localparam logic [3:0] PH_EPAD   = 4'd11;
    localparam logic [3:0] PH_IDLE   = 4'd12;

    // record kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BUF_SIZE   = 3'd1;
    localparam logic [2:0] ERR_INCOMPLETE = 3'd2;
    localparam logic [2:0] ERR_AUTH_COUNT = 3'd3;
    localparam logic [2:0] ERR_NDR64      = 3'd4;

    // register indexes
    localparam logic [2:0] REG_NDR64      = 3'd0;
    localparam logic [2:0] REG_BIG_ENDIAN = 3'd1;
    localparam logic [2:0] REG_NO_ALIGN   = 3'd2;
    localparam logic [2:0] REG_INCOMPLETE = 3'd3;
    localparam logic [2:0] REG_START      = 3'd4;

    typedef struct packed {
        logic       ndr64_mode;
        logic       big_endian;
        logic       no_align;
        logic       incomplete_mode;
        logic [2:0] start_phase;
    } cfg_t;

    typedef struct packed {
        logic [31:0] last_sub_authority;
        logic [47:0] identifier_authority;
        logic [3:0]  sid_auth_count;
        logic [7:0]  sid_revision;
        logic [31:0] rights_mask;
        logic [7:0]  entry_flags;
        logic [7:0]  entry_type;
        logic [31:0] entry_count;
        logic [15:0] size_value;
        logic [15:0] revision;
        logic [2:0]  error_code;
        logic [1:0]  kind;
    } rec_t;

endpackage

// File: rtl/ndr_acl_stream_parser_top.sv
// The record for an accepted byte is registered directly into the output register.
// Throughput: one byte per cycle while s_tready is high; the field state machine
// updates in a single pass. The output register is a one-deep buffer: a new byte
// is taken while the record is taken in the same cycle or when none is pending.
// Reset (rst_n, asynchronous, active low) clears registers, parser state and output.
module ndr_acl_stream_parser_top
    import nasp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte[7:0]
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // error_code[2:0], revision[18:3], size_value[34:19],
    // entry_count[66:35], entry_type[74:67], entry_flags[82:75],
    // rights_mask[114:83], sid_revision[122:115], sid_auth_count[126:123],
    // identifier_authority[174:127], last_sub_authority[206:175], zero fill
    output logic [207:0] m_tdata,
    output logic [1:0]   m_tuser,   // kind[1:0]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t cfg;

    nasp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] off_reg, off_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  fb_reg, fb_next;
    logic [31:0] left_reg, left_next;
    logic [15:0] estart_reg, estart_next;
    logic [15:0] pad_reg, pad_next;
    logic [3:0]  subs_reg, subs_next;
    logic [63:0] cap_reg, cap_next;
    logic [47:0] auth_reg, auth_next;
    logic [31:0] lsub_reg, lsub_next;
    logic [7:0]  srev_reg, srev_next;
    logic [3:0]  scnt_reg, scnt_next;
    logic        start_reg, start_next;
    logic        ovalid_reg;
    rec_t        orec_reg;
    rec_t        rec;
    logic        emit;
    logic        accept;

    logic [15:0] off, nxt, used;
    logic [2:0]  align_m;
    logic [2:0]  flen;
    logic [31:0] v;
    logic [7:0]  b;
    logic [2:0]  tcode;
    logic        done;

    assign s_tready = !ovalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {1'b0, orec_reg[208:2]};
    assign m_tuser  = orec_reg.kind;
    assign b        = s_tdata;
    assign tcode    = cfg.incomplete_mode ? ERR_INCOMPLETE : ERR_BUF_SIZE;

    // parse one byte
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        fb_next     = fb_reg;
        left_next   = left_reg;
        estart_next = estart_reg;
        pad_next    = pad_reg;
        subs_next   = subs_reg;
        cap_next    = cap_reg;
        auth_next   = auth_reg;
        lsub_next   = lsub_reg;
        srev_next   = srev_reg;
        scnt_next   = scnt_reg;
        start_next  = 1'b0;
        rec         = '0;
        emit        = 1'b0;
        done        = 1'b0;
        v           = '0;
        used        = '0;
        off         = start_reg ? {13'd0, cfg.start_phase} : off_reg;
        nxt         = off + 16'd1;
        align_m     = 3'd0;
        flen        = 3'd1;

        unique case (phase_reg)
            PH_REV:                      begin align_m = 3'd3; flen = cfg.ndr64_mode ? 3'd4 : 3'd2; end
            PH_SIZE, PH_ESIZE:           begin align_m = 3'd1; flen = 3'd2; end
            PH_COUNT, PH_EMASK, PH_SSUB: begin align_m = 3'd3; flen = 3'd4; end
            PH_ETYPE, PH_SREV:           begin align_m = 3'd3; flen = 3'd1; end
            PH_SAUTH:                    begin align_m = 3'd0; flen = 3'd6; end
            default:                     begin align_m = 3'd0; flen = 3'd1; end
        endcase

        if (phase_reg == PH_EPAD)
        begin
            pad_next = pad_reg - 16'd1;
            if (pad_next == 16'd0)
                done = 1'b1;
        end
        else if (phase_reg < PH_EPAD)
        begin
            if (!cfg.no_align && fb_reg == 3'd0 && (off[2:0] & align_m) != 3'd0)
            begin
                // alignment pad: drop byte
            end
            else
            begin
                if (phase_reg == PH_SAUTH)
                    auth_next = {auth_reg[39:0], b};
                else if (cfg.big_endian)
                    acc_next = {acc_reg[23:0], b};
                else
                    acc_next = acc_reg | ({24'd0, b} << {fb_reg[1:0], 3'b000});
                fb_next = fb_reg + 3'd1;
                if (fb_next >= flen)
                begin
                    fb_next = 3'd0;
                    v = acc_next;
                    acc_next = '0;
                    unique case (phase_reg)
                        PH_REV:
                        begin
                            if (cfg.ndr64_mode && v[31:16] != 16'd0)
                            begin
                                emit = 1'b1;
                                rec.kind = KIND_ERROR;
                                rec.error_code = ERR_NDR64;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                cap_next = {48'd0, v[15:0]};
                                phase_next = PH_SIZE;
                            end
                        end
                        PH_SIZE:
                        begin
                            cap_next[31:16] = v[15:0];
                            phase_next = PH_COUNT;
                        end
                        PH_COUNT:
                        begin
                            emit = 1'b1;
                            rec.kind = KIND_HEADER;
                            rec.revision = cap_reg[15:0];
                            rec.size_value = cap_reg[31:16];
                            rec.entry_count = v;
                            left_next = v;
                            if (v == 32'd0)
                                phase_next = PH_IDLE;
                            else
                            begin
                                phase_next = PH_ETYPE;
                                estart_next = nxt;
                            end
                        end
                        PH_ETYPE:
                        begin
                            cap_next = {56'd0, v[7:0]};
                            phase_next = PH_EFLAGS;
                        end
                        PH_EFLAGS:
                        begin
                            cap_next[15:8] = v[7:0];
                            phase_next = PH_ESIZE;
                        end
                        PH_ESIZE:
                        begin
                            cap_next[31:16] = v[15:0];
                            phase_next = PH_EMASK;
                        end
                        PH_EMASK:
                        begin
                            cap_next[63:32] = v;
                            phase_next = PH_SREV;
                        end
                        PH_SREV:
                        begin
                            srev_next = b;
                            phase_next = PH_SCOUNT;
                        end
                        PH_SCOUNT:
                        begin
                            if (b > 8'(MAX_SUB_AUTHS))
                            begin
                                emit = 1'b1;
                                rec.kind = KIND_ERROR;
                                rec.error_code = ERR_AUTH_COUNT;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                subs_next = b[3:0];
                                scnt_next = b[3:0];
                                lsub_next = '0;
                                auth_next = '0;
                                phase_next = PH_SAUTH;
                            end
                        end
                        PH_SAUTH:
                        begin
                            if (subs_reg == 4'd0)
                                phase_next = PH_EPAD;
                            else
                                phase_next = PH_SSUB;
                        end
                        PH_SSUB:
                        begin
                            lsub_next = v;
                            subs_next = subs_reg - 4'd1;
                            if (subs_next == 4'd0)
                                phase_next = PH_EPAD;
                        end
                        default: ;
                    endcase
                    // identifier complete: check entry size and set padding
                    if (phase_next == PH_EPAD)
                    begin
                        used = nxt - estart_reg;
                        if (cap_reg[31:16] < used)
                        begin
                            emit = 1'b1;
                            rec.kind = KIND_ERROR;
                            rec.error_code = tcode;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            pad_next = cap_reg[31:16] - used;
                            if (pad_next == 16'd0)
                                done = 1'b1;
                        end
                    end
                end
            end
        end

        // emit entry record
        if (done)
        begin
            emit = 1'b1;
            rec.kind = KIND_ENTRY;
            rec.size_value = cap_reg[31:16];
            rec.entry_type = cap_reg[7:0];
            rec.entry_flags = cap_reg[15:8];
            rec.rights_mask = cap_reg[63:32];
            rec.sid_revision = srev_reg;
            rec.sid_auth_count = scnt_reg;
            rec.identifier_authority = auth_next;
            rec.last_sub_authority = lsub_next;
            left_next = left_reg - 32'd1;
            if (left_next == 32'd0)
                phase_next = PH_IDLE;
            else
            begin
                phase_next = PH_ETYPE;
                estart_next = nxt;
            end
        end

        off_next = nxt;

        // end of buffer: flag truncation and restart
        if (s_tlast)
        begin
            if (phase_next != PH_IDLE)
            begin
                emit = 1'b1;
                rec = '0;
                rec.kind = KIND_ERROR;
                rec.error_code = tcode;
            end
            phase_next  = PH_REV;
            acc_next    = '0;
            fb_next     = '0;
            left_next   = '0;
            estart_next = '0;
            pad_next    = '0;
            subs_next   = '0;
            cap_next    = '0;
            auth_next   = '0;
            lsub_next   = '0;
            srev_next   = '0;
            scnt_next   = '0;
            start_next  = 1'b1;
        end
    end

    // advance parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_REV;
            off_reg    <= '0;
            acc_reg    <= '0;
            fb_reg     <= '0;
            left_reg   <= '0;
            estart_reg <= '0;
            pad_reg    <= '0;
            subs_reg   <= '0;
            cap_reg    <= '0;
            auth_reg   <= '0;
            lsub_reg   <= '0;
            srev_reg   <= '0;
            scnt_reg   <= '0;
            start_reg  <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            off_reg    <= off_next;
            acc_reg    <= acc_next;
            fb_reg     <= fb_next;
            left_reg   <= left_next;
            estart_reg <= estart_next;
            pad_reg    <= pad_next;
            subs_reg   <= subs_next;
            cap_reg    <= cap_next;
            auth_reg   <= auth_next;
            lsub_reg   <= lsub_next;
            srev_reg   <= srev_next;
            scnt_reg   <= scnt_next;
            start_reg  <= start_next;
        end
    end

    // hold result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            ovalid_reg <= emit;
        end
        else if (m_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            orec_reg <= '0;
        else if (accept && emit)
            orec_reg <= rec;
    end

    // checks
    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && orec_reg.kind != KIND_ERROR |-> orec_reg.error_code == ERR_NONE)
        else $error("error code on non-error record");
    a_auth_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && orec_reg.kind == KIND_ENTRY |-> orec_reg.sid_auth_count <= 4'(MAX_SUB_AUTHS))
        else $error("authority count out of range");
    a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> phase_reg == PH_REV && start_reg)
        else $error("no restart after last byte");
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> orec_reg.kind != 2'd3)
        else $error("bad record kind");

endmodule

// File: rtl/nasp_cfg_regs.sv
module nasp_cfg_regs
    import nasp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // write registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[4:2])
                REG_NDR64:      cfg_reg.ndr64_mode      <= pwdata[0];
                REG_BIG_ENDIAN: cfg_reg.big_endian      <= pwdata[0];
                REG_NO_ALIGN:   cfg_reg.no_align        <= pwdata[0];
                REG_INCOMPLETE: cfg_reg.incomplete_mode <= pwdata[0];
                REG_START:      cfg_reg.start_phase     <= pwdata[2:0];
                default:        ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            unique case (paddr[4:2])
                REG_NDR64:      prdata[0]   = cfg_reg.ndr64_mode;
                REG_BIG_ENDIAN: prdata[0]   = cfg_reg.big_endian;
                REG_NO_ALIGN:   prdata[0]   = cfg_reg.no_align;
                REG_INCOMPLETE: prdata[0]   = cfg_reg.incomplete_mode;
                REG_START:      prdata[2:0] = cfg_reg.start_phase;
                default:        prdata      = '0;
            endcase
        end
    end

endmodule
